// ----- design/bgc_pkg.sv -----
// Shared types and constants for the button gesture controller.
package bgc_pkg;

    // Brightness limits of the ramp.
    localparam logic [7:0] BRIGHT_MIN = 8'd1;
    localparam logic [7:0] BRIGHT_MAX = 8'd255;

    // Gesture constants.
    localparam logic [2:0]  CLICKS_ENTER_RAINBOW = 3'd5;
    localparam logic [2:0]  CLICKS_LEAVE_RAINBOW = 3'd4;
    localparam logic [15:0] HOLD_SATURATE        = 16'hFFFF;
    localparam logic [7:0]  FRAME_INTERVAL_RESET = 8'd10;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE_TICKS    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS_TICKS  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_INTERVAL     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLICK_TIMEOUT     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_ADJUST      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAINBOW_FASTEST   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAINBOW_SLOWEST   = 3'd6;

    // Configuration reset values.
    localparam logic [7:0]  RST_DEBOUNCE_TICKS    = 8'd3;
    localparam logic [15:0] RST_LONG_PRESS_TICKS  = 16'd100;
    localparam logic [7:0]  RST_RAMP_INTERVAL     = 8'd2;
    localparam logic [7:0]  RST_CLICK_TIMEOUT     = 8'd40;
    localparam logic [7:0]  RST_SPEED_ADJUST      = 8'd10;
    localparam logic [7:0]  RST_RAINBOW_FASTEST   = 8'd2;
    localparam logic [7:0]  RST_RAINBOW_SLOWEST   = 8'd40;

    // Stream widths.
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 32;

    // Current configuration as seen by the gesture logic.
    typedef struct packed {
        logic [7:0]  debounce_ticks;
        logic [15:0] long_press_ticks;
        logic [7:0]  ramp_interval_ticks;
        logic [7:0]  click_timeout_ticks;
        logic [7:0]  speed_adjust_ticks;
        logic [7:0]  rainbow_fastest;
        logic [7:0]  rainbow_slowest;
    } bgc_cfg_t;

    // One result item.
    typedef struct packed {
        logic [7:0] rainbow_period;
        logic       rainbow_on;
        logic [1:0] rainbow_steps;
        logic       apply_color;
        logic [2:0] color_advances;
        logic       save_request;
        logic       limit_hit;
        logic [7:0] brightness;
    } bgc_result_t;

endpackage

// ----- design/bgc_cfg_regs.sv -----
// Configuration register file of the button gesture controller.
module bgc_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bgc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output bgc_pkg::bgc_cfg_t                cfg
);

    bgc_pkg::bgc_cfg_t cfg_reg;
    bgc_pkg::bgc_cfg_t cfg_next;

    // Writes are always accepted.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index of a write transaction; unknown indexes are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_addr)
                bgc_pkg::CFG_DEBOUNCE_TICKS:    cfg_next.debounce_ticks      = cfg_wdata[7:0];
                bgc_pkg::CFG_LONG_PRESS_TICKS:  cfg_next.long_press_ticks    = cfg_wdata[15:0];
                bgc_pkg::CFG_RAMP_INTERVAL:     cfg_next.ramp_interval_ticks = cfg_wdata[7:0];
                bgc_pkg::CFG_CLICK_TIMEOUT:     cfg_next.click_timeout_ticks = cfg_wdata[7:0];
                bgc_pkg::CFG_SPEED_ADJUST:      cfg_next.speed_adjust_ticks  = cfg_wdata[7:0];
                bgc_pkg::CFG_RAINBOW_FASTEST:   cfg_next.rainbow_fastest     = cfg_wdata[7:0];
                bgc_pkg::CFG_RAINBOW_SLOWEST:   cfg_next.rainbow_slowest     = cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Register storage with reset defaults.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks      <= bgc_pkg::RST_DEBOUNCE_TICKS;
            cfg_reg.long_press_ticks    <= bgc_pkg::RST_LONG_PRESS_TICKS;
            cfg_reg.ramp_interval_ticks <= bgc_pkg::RST_RAMP_INTERVAL;
            cfg_reg.click_timeout_ticks <= bgc_pkg::RST_CLICK_TIMEOUT;
            cfg_reg.speed_adjust_ticks  <= bgc_pkg::RST_SPEED_ADJUST;
            cfg_reg.rainbow_fastest     <= bgc_pkg::RST_RAINBOW_FASTEST;
            cfg_reg.rainbow_slowest     <= bgc_pkg::RST_RAINBOW_SLOWEST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/bgc_gesture_core.sv -----
// Gesture state and its single-pass update for one tick.
module bgc_gesture_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic                   raw_key,
    input  bgc_pkg::bgc_cfg_t      cfg,
    output bgc_pkg::bgc_result_t   result
);

    typedef struct packed {
        logic [7:0]  debounce_count;
        logic        stable_level;
        logic [15:0] hold_count;
        logic        ramping;
        logic        ramp_rising;
        logic        ramp_stopped;
        logic [7:0]  ramp_divider;
        logic [2:0]  click_tally;
        logic [7:0]  click_idle;
        logic        rainbow_active;
        logic        speed_up_next;
        logic [7:0]  frame_interval;
        logic [7:0]  frame_divider;
        logic [7:0]  adjust_divider;
        logic [7:0]  level;
    } gesture_state_t;

    gesture_state_t state_reg;
    gesture_state_t state_next;

    logic       limit_hit;
    logic       save_request;
    logic [2:0] color_advances;
    logic       apply_color;
    logic [1:0] rainbow_steps;

    // Next state and event fields for the tick held in the input register.
    always_comb begin
        state_next     = state_reg;
        limit_hit      = 1'b0;
        save_request   = 1'b0;
        color_advances = 3'd0;
        apply_color    = 1'b0;
        rainbow_steps  = 2'd0;

        // Debounce: a changed level must persist before it is taken.
        if (raw_key != state_reg.stable_level) begin
            state_next.debounce_count = state_reg.debounce_count + 8'd1;
            if (state_next.debounce_count >= cfg.debounce_ticks) begin
                state_next.debounce_count = 8'd0;
                state_next.stable_level   = raw_key;
                if (!raw_key) begin
                    // Press edge.
                    state_next.hold_count     = 16'd0;
                    state_next.ramping        = 1'b0;
                    state_next.ramp_stopped   = 1'b0;
                    state_next.ramp_divider   = 8'd0;
                    state_next.adjust_divider = 8'd0;
                end else begin
                    // Release edge: end of a long press or a click.
                    if (state_reg.ramping) begin
                        if (state_reg.rainbow_active) begin
                            state_next.speed_up_next = ~state_reg.speed_up_next;
                        end else begin
                            save_request = 1'b1;
                        end
                    end else begin
                        state_next.click_tally = state_reg.click_tally + 3'd1;
                        state_next.click_idle  = 8'd0;
                        if (!state_reg.rainbow_active &&
                            state_next.click_tally >= bgc_pkg::CLICKS_ENTER_RAINBOW) begin
                            state_next.rainbow_active = 1'b1;
                            state_next.click_tally    = 3'd0;
                            state_next.frame_divider  = 8'd0;
                            rainbow_steps             = 2'd1;
                        end else if (state_reg.rainbow_active &&
                            state_next.click_tally >= bgc_pkg::CLICKS_LEAVE_RAINBOW) begin
                            state_next.rainbow_active = 1'b0;
                            state_next.click_tally    = 3'd0;
                            apply_color               = 1'b1;
                        end
                    end
                    state_next.ramping = 1'b0;
                end
            end
        end else begin
            state_next.debounce_count = 8'd0;
        end

        // Held button: long press detection, speed adjust or brightness ramp.
        if (!state_next.stable_level) begin
            if (state_next.hold_count < bgc_pkg::HOLD_SATURATE) begin
                state_next.hold_count = state_next.hold_count + 16'd1;
            end
            if (!state_next.ramping && state_next.hold_count >= cfg.long_press_ticks) begin
                state_next.click_tally = 3'd0;
                state_next.ramping     = 1'b1;
                if (!state_next.rainbow_active) begin
                    if (state_next.level >= bgc_pkg::BRIGHT_MAX) begin
                        state_next.ramp_rising = 1'b0;
                    end else if (state_next.level <= bgc_pkg::BRIGHT_MIN) begin
                        state_next.ramp_rising = 1'b1;
                    end
                end
            end else if (state_next.ramping && state_next.rainbow_active) begin
                state_next.adjust_divider = state_next.adjust_divider + 8'd1;
                if (state_next.adjust_divider >= cfg.speed_adjust_ticks) begin
                    state_next.adjust_divider = 8'd0;
                    if (state_next.speed_up_next &&
                        state_next.frame_interval > cfg.rainbow_fastest) begin
                        state_next.frame_interval = state_next.frame_interval - 8'd1;
                    end
                    if (!state_next.speed_up_next &&
                        state_next.frame_interval < cfg.rainbow_slowest) begin
                        state_next.frame_interval = state_next.frame_interval + 8'd1;
                    end
                end
            end else if (state_next.ramping && !state_next.ramp_stopped) begin
                state_next.ramp_divider = state_next.ramp_divider + 8'd1;
                if (state_next.ramp_divider >= cfg.ramp_interval_ticks) begin
                    state_next.ramp_divider = 8'd0;
                    if (state_next.ramp_rising) begin
                        if (state_next.level < bgc_pkg::BRIGHT_MAX) begin
                            state_next.level = state_next.level + 8'd1;
                        end
                        limit_hit = (state_next.level >= bgc_pkg::BRIGHT_MAX);
                    end else begin
                        if (state_next.level > bgc_pkg::BRIGHT_MIN) begin
                            state_next.level = state_next.level - 8'd1;
                        end
                        limit_hit = (state_next.level <= bgc_pkg::BRIGHT_MIN);
                    end
                    if (limit_hit) begin
                        state_next.ramp_rising  = ~state_next.ramp_rising;
                        state_next.ramp_stopped = 1'b1;
                    end
                end
            end
        end else if (state_next.click_tally != 3'd0) begin
            // Released with clicks pending: wait for the run to end.
            state_next.click_idle = state_next.click_idle + 8'd1;
            if (state_next.click_idle >= cfg.click_timeout_ticks) begin
                if (!state_next.rainbow_active) begin
                    color_advances = state_next.click_tally;
                    save_request   = 1'b1;
                end
                state_next.click_tally = 3'd0;
                state_next.click_idle  = 8'd0;
            end
        end

        // Rainbow frame pacing.
        if (state_next.rainbow_active) begin
            state_next.frame_divider = state_next.frame_divider + 8'd1;
            if (state_next.frame_divider >= state_next.frame_interval) begin
                state_next.frame_divider = 8'd0;
                rainbow_steps            = rainbow_steps + 2'd1;
            end
        end
    end

    // Result item for this tick.
    always_comb begin
        result.brightness     = state_next.level;
        result.limit_hit      = limit_hit;
        result.save_request   = save_request;
        result.color_advances = color_advances;
        result.apply_color    = apply_color;
        result.rainbow_steps  = rainbow_steps;
        result.rainbow_on     = state_next.rainbow_active;
        result.rainbow_period = state_next.frame_interval;
    end

    // State registers, updated once per processed tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.debounce_count <= 8'd0;
            state_reg.stable_level   <= 1'b1;
            state_reg.hold_count     <= 16'd0;
            state_reg.ramping        <= 1'b0;
            state_reg.ramp_rising    <= 1'b0;
            state_reg.ramp_stopped   <= 1'b0;
            state_reg.ramp_divider   <= 8'd0;
            state_reg.click_tally    <= 3'd0;
            state_reg.click_idle     <= 8'd0;
            state_reg.rainbow_active <= 1'b0;
            state_reg.speed_up_next  <= 1'b1;
            state_reg.frame_interval <= bgc_pkg::FRAME_INTERVAL_RESET;
            state_reg.frame_divider  <= 8'd0;
            state_reg.adjust_divider <= 8'd0;
            state_reg.level          <= bgc_pkg::BRIGHT_MAX;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/button_gesture_controller_core.sv -----
// Top level of the button gesture controller: stream ports, input and result registers.
//
// The block takes one sampled button level per transaction and returns exactly one
// result transaction for it. It sustains one item per clock cycle while the result
// stream is not stalled; an item is held in the input register and is then offered
// from the result register, and the whole debounce, gesture and pacing update is one
// pass of logic from the registered input to the gesture state. A result that is not
// taken holds in the result register while one further item waits in the input
// register. Configuration writes are always accepted and should be made while no
// item is in flight. No clearing pass follows reset.
module button_gesture_controller_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input stream: tdata[0] raw_key, tdata[7:1] zero.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [bgc_pkg::S_TDATA_W-1:0]        s_tdata,
    // Result stream: tdata[7:0] brightness, [8] limit_hit, [9] save_request,
    // [12:10] color_advances, [13] apply_color, [15:14] rainbow_steps,
    // [16] rainbow_on, [24:17] rainbow_period, [31:25] zero.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [bgc_pkg::M_TDATA_W-1:0]        m_tdata,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bgc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int unsigned RESULT_W = $bits(bgc_pkg::bgc_result_t);

    bgc_pkg::bgc_cfg_t    cfg;
    bgc_pkg::bgc_result_t result;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic                 in_raw_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    bgc_pkg::bgc_result_t out_result_reg;
    logic                 advance;

    bgc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bgc_gesture_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .raw_key (in_raw_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Flow control: the held item moves on when the result register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_raw_reg <= s_tdata[0];
        end
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bgc_pkg::M_TDATA_W - RESULT_W){1'b0}}, out_result_reg};

endmodule

// ----- design/bgc_checker.sv -----
// Port-level assertions for the button gesture controller, bound to the top level.
module bgc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bgc_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Colour advances come only with a save request and never exceed four.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[12:10] != 3'd0) |-> m_tdata[9] && (m_tdata[12:10] <= 3'd4))
        else $error("colour advances without save or out of range");

    // Leaving rainbow mode shows rainbow off in the same result, and at most two frames.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[13] || !m_tdata[16]) && (m_tdata[15:14] != 2'd3))
        else $error("inconsistent rainbow fields");

    // An accepted item always yields a valid result on the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("accepted item produced no result");

    // Padding bits of the result stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:25] == 7'd0)
        else $error("result padding not zero");

endmodule

bind button_gesture_controller_core bgc_checker u_bgc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
